// ----- design/stsr_pkg.sv -----
// shared types and constants for the stepped track range stats core
`default_nettype none
package stsr_pkg;

    localparam int POS_W   = 32;
    localparam int VAL_W   = 32;
    localparam int AREA_W  = 64;
    localparam int MAX_W   = 31;
    localparam int STEP_W  = 16;
    localparam int DVD_W   = 64;
    localparam int DVS_W   = 33;

    localparam int TABLE_DEPTH = 4096;
    localparam int ENTRY_W     = $clog2(TABLE_DEPTH + 1);

    typedef logic [1:0] req_code_t;
    typedef logic [1:0] status_t;

    localparam req_code_t REQ_NEW   = 2'd0;
    localparam req_code_t REQ_LOAD  = 2'd1;
    localparam req_code_t REQ_QUERY = 2'd2;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_FULL   = 2'd1;
    localparam status_t ST_RANGE  = 2'd2;
    localparam status_t ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

// ----- design/stsr_if.sv -----
// request and result channel interfaces
`default_nettype none
interface stsr_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     req_type;
    logic [31:0]                    position;
    logic signed [31:0]             sample_value;
    logic [31:0]                    range_end;

    modport source (output valid, req_type, position, sample_value, range_end, input ready);
    modport sink (input valid, req_type, position, sample_value, range_end, output ready);
endinterface

interface stsr_res_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic signed [31:0]             mean_value;
    logic signed [63:0]             area_value;
    logic [30:0]                    max_value;
    logic [stsr_pkg::ENTRY_W-1:0]   entries_stored;

    modport source (output valid, status, mean_value, area_value, max_value, entries_stored,
                    input ready);
    modport sink (input valid, status, mean_value, area_value, max_value, entries_stored,
                  output ready);
endinterface
`default_nettype wire

// ----- design/stsr_div.sv -----
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module stsr_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire stsr_pkg::div_ctrl_t        ctrl,
    input  wire logic [stsr_pkg::DVD_W-1:0] dividend,
    input  wire logic [stsr_pkg::DVS_W-1:0] divisor,
    output stsr_pkg::div_stat_t             stat,
    output logic [stsr_pkg::DVD_W-1:0]      quotient,
    output logic [stsr_pkg::DVS_W-1:0]      remainder
);
    import stsr_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DVS_W:0]     rem_reg;
    logic [DVD_W-1:0]   quo_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVS_W:0]     shifted;
    logic [DVS_W:0]     diff;

    assign shifted = {rem_reg[DVS_W-1:0], quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DVS_W])
            begin
                rem_reg <= diff;
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[DVS_W-1:0];

endmodule
`default_nettype wire

// ----- design/stepped_track_range_stats_core.sv -----
// top level: block table, load and query sequencer around a shared divider
//
// channel   dir  signals
// req_ch    in   valid/ready, req_type, position, sample_value, range_end
// res_ch    out  valid/ready, status, mean_value, area_value, max_value, entries_stored
// cfg       in   cfg_we, cfg_wdata (step_size)
//
// one request at a time; ready is high only while the sequencer is idle
// load: writes zero fill blocks to close the gap to the sample position, then the sample
// query: two divisions of 64 quotient bits find the first and last block, the blocks
// are walked (read, multiply, accumulate), then one more division gives the mean
// reset clears the track registers and fill count; the table needs no clearing
// a stalled result beat holds in the output register and the sequencer waits on it
`default_nettype none
module stepped_track_range_stats_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [15:0]                cfg_wdata,
    stsr_req_if.sink                        req_ch,
    stsr_res_if.source                      res_ch
);
    import stsr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = ENTRY_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_QDIV0,
        S_QDIV1,
        S_QRD,
        S_QMUL,
        S_QACC,
        S_QMEAN,
        S_QFIN,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [STEP_W-1:0]      step_cfg_reg;
    logic [POS_W-1:0]       track_start_reg;
    logic [POS_W-1:0]       last_pos_reg;
    logic                   has_data_reg;
    logic [CW-1:0]          count_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [VAL_W-1:0]       val_reg;
    logic [POS_W-1:0]       lo_reg;
    logic [POS_W-1:0]       hi_reg;
    logic [DVS_W-1:0]       k0_reg;
    logic [CW-1:0]          k1_reg;
    logic [CW-1:0]          k_reg;
    logic [POS_W+1:0]       bs_reg;
    logic [16:0]            ov_reg;
    logic signed [VAL_W-1:0] rd_data_reg;
    logic signed [49:0]     prod_reg;
    logic signed [AREA_W-1:0] sum_reg;
    logic signed [VAL_W-1:0] best_reg;
    logic                   div_start_reg;
    logic [DVD_W-1:0]       div_dvd_reg;
    logic [DVS_W-1:0]       div_dvs_reg;
    status_t                st_reg;
    logic signed [VAL_W-1:0] mean_reg;

    logic                   res_valid_reg;
    status_t                res_status_reg;
    logic signed [31:0]     res_mean_reg;
    logic signed [63:0]     res_area_reg;
    logic [MAX_W-1:0]       res_max_reg;
    logic [CW-1:0]          res_cnt_reg;

    logic signed [VAL_W-1:0] mem [TABLE_DEPTH];
    logic                   mem_we;
    logic [VAL_W-1:0]       mem_wdata;

    logic [STEP_W-1:0]      step;
    logic                   full;
    logic                   fill_more;
    logic [POS_W-1:0]       a_lo;
    logic [POS_W-1:0]       a_hi;
    logic [POS_W+1:0]       be;
    logic [POS_W+1:0]       ov_s;
    logic [POS_W+1:0]       ov_e;
    logic [POS_W+1:0]       ov_full;
    logic [DVS_W-1:0]       cap;
    logic                   sum_neg;
    logic [DVD_W-1:0]       sum_mag;
    logic [DVD_W-1:0]       div_q;
    logic [DVS_W-1:0]       div_r;
    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;
    logic                   out_free;

    assign step      = (step_cfg_reg == '0) ? STEP_W'(1) : step_cfg_reg;
    assign full      = (count_reg == CW'(TABLE_DEPTH));
    assign fill_more = (({1'b0, last_pos_reg} + {17'd0, step}) < {1'b0, pos_reg});
    assign a_lo      = (req_ch.position < req_ch.range_end) ? req_ch.position : req_ch.range_end;
    assign a_hi      = (req_ch.position < req_ch.range_end) ? req_ch.range_end : req_ch.position;
    assign be        = bs_reg + {18'd0, step} - 34'd1;
    assign ov_s      = (bs_reg > {2'b00, lo_reg}) ? bs_reg : {2'b00, lo_reg};
    assign ov_e      = (be < {2'b00, hi_reg}) ? be : {2'b00, hi_reg};
    assign ov_full   = ov_e - ov_s + 34'd1;
    assign cap       = DVS_W'(count_reg - 1'b1);
    assign sum_neg   = sum_reg[AREA_W-1];
    assign sum_mag   = sum_neg ? DVD_W'(-sum_reg) : DVD_W'(sum_reg);
    assign out_free  = !res_valid_reg || res_ch.ready;
    assign div_ctrl.start = div_start_reg;

    assign mem_we    = (state_reg == S_FILL) && !full;
    assign mem_wdata = fill_more ? '0 : val_reg;

    stsr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dvd_reg),
        .divisor   (div_dvs_reg),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= mem_wdata;
        end
        rd_data_reg <= mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_cfg_reg    <= STEP_W'(1);
            track_start_reg <= '0;
            last_pos_reg    <= '0;
            has_data_reg    <= 1'b0;
            count_reg       <= '0;
            div_start_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (cfg_we)
            begin
                step_cfg_reg <= cfg_wdata;
            end
            if (res_valid_reg && res_ch.ready && (state_reg != S_OUT))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    sum_reg  <= '0;
                    best_reg <= '0;
                    mean_reg <= '0;
                    st_reg   <= ST_OK;
                    pos_reg  <= req_ch.position;
                    val_reg  <= req_ch.sample_value;
                    lo_reg   <= a_lo;
                    hi_reg   <= a_hi;
                    if (req_ch.valid)
                    begin
                        case (req_ch.req_type)
                            REQ_NEW:
                            begin
                                track_start_reg <= '0;
                                last_pos_reg    <= '0;
                                has_data_reg    <= 1'b0;
                                count_reg       <= '0;
                                state_reg       <= S_OUT;
                            end
                            REQ_LOAD:
                            begin
                                if (!has_data_reg && !full)
                                begin
                                    has_data_reg    <= 1'b1;
                                    track_start_reg <= req_ch.position;
                                    last_pos_reg    <= req_ch.position;
                                end
                                state_reg <= S_FILL;
                            end
                            REQ_QUERY:
                            begin
                                if (!has_data_reg)
                                begin
                                    st_reg    <= ST_RANGE;
                                    state_reg <= S_OUT;
                                end
                                else if (a_lo == a_hi)
                                begin
                                    st_reg    <= ST_EMPTY;
                                    state_reg <= S_OUT;
                                end
                                else if (a_lo < track_start_reg || a_hi > last_pos_reg)
                                begin
                                    st_reg    <= ST_RANGE;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    div_dvd_reg   <= DVD_W'(a_lo - track_start_reg);
                                    div_dvs_reg   <= DVS_W'(step);
                                    div_start_reg <= 1'b1;
                                    state_reg     <= S_QDIV0;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_FILL:
                begin
                    if (full)
                    begin
                        st_reg    <= ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (fill_more)
                        begin
                            last_pos_reg <= last_pos_reg + POS_W'(step);
                        end
                        else
                        begin
                            last_pos_reg <= pos_reg;
                            state_reg    <= S_OUT;
                        end
                    end
                end
                S_QDIV0:
                begin
                    if (div_stat.done)
                    begin
                        k0_reg        <= div_q[DVS_W-1:0];
                        bs_reg        <= {2'b00, lo_reg - div_r[POS_W-1:0]};
                        div_dvd_reg   <= DVD_W'(hi_reg - track_start_reg);
                        div_start_reg <= 1'b1;
                        state_reg     <= S_QDIV1;
                    end
                end
                S_QDIV1:
                begin
                    if (div_stat.done)
                    begin
                        if (div_q[DVS_W-1:0] > cap)
                        begin
                            k1_reg <= cap[CW-1:0];
                        end
                        else
                        begin
                            k1_reg <= div_q[CW-1:0];
                        end
                        k_reg <= k0_reg[CW-1:0];
                        if (k0_reg > ((div_q[DVS_W-1:0] > cap) ? cap : div_q[DVS_W-1:0]))
                        begin
                            state_reg <= S_QMEAN;
                        end
                        else
                        begin
                            state_reg <= S_QRD;
                        end
                    end
                end
                S_QRD:
                begin
                    ov_reg    <= ov_full[16:0];
                    state_reg <= S_QMUL;
                end
                S_QMUL:
                begin
                    prod_reg <= rd_data_reg * $signed({1'b0, ov_reg});
                    if (rd_data_reg > best_reg)
                    begin
                        best_reg <= rd_data_reg;
                    end
                    state_reg <= S_QACC;
                end
                S_QACC:
                begin
                    sum_reg <= sum_reg + AREA_W'(prod_reg);
                    bs_reg  <= bs_reg + {18'd0, step};
                    k_reg   <= k_reg + 1'b1;
                    if (k_reg == k1_reg)
                    begin
                        state_reg <= S_QMEAN;
                    end
                    else
                    begin
                        state_reg <= S_QRD;
                    end
                end
                S_QMEAN:
                begin
                    div_dvd_reg   <= sum_mag;
                    div_dvs_reg   <= {1'b0, hi_reg} - {1'b0, lo_reg} + DVS_W'(1);
                    div_start_reg <= 1'b1;
                    state_reg     <= S_QFIN;
                end
                S_QFIN:
                begin
                    if (div_stat.done)
                    begin
                        mean_reg  <= sum_neg ? VAL_W'(-div_q) : div_q[VAL_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg  <= 1'b1;
                        res_status_reg <= st_reg;
                        res_mean_reg   <= mean_reg;
                        res_area_reg   <= sum_reg;
                        res_max_reg    <= best_reg[MAX_W-1:0];
                        res_cnt_reg    <= count_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ch.ready          = (state_reg == S_IDLE);
    assign res_ch.valid          = res_valid_reg;
    assign res_ch.status         = res_status_reg;
    assign res_ch.mean_value     = res_mean_reg;
    assign res_ch.area_value     = res_area_reg;
    assign res_ch.max_value      = res_max_reg;
    assign res_ch.entries_stored = res_cnt_reg;

endmodule
`default_nettype wire
